@@ sv/tsp_pkg.sv @@
// tsp_pkg: shared widths, command and action codes, note word layout
// for the tone sequence player; no dependencies

package tsp_pkg;

    localparam int MAX_NOTES_DEF = 64;
    localparam int IDX_W         = 8;
    localparam int CMD_W         = 3;
    localparam int ACT_W         = 2;
    localparam int TONE_W        = 8;
    localparam int LEN_W         = 7;
    localparam int DUR_W         = 16;
    localparam int TEMPO_W       = 8;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 8;

    localparam logic [CMD_W-1:0] CMD_NEW_SONG = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD_NOTE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_START    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_STOP     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TICK     = 3'd4;

    localparam logic [ACT_W-1:0] ACT_NONE    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_TONE    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_SILENCE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_NOTE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMPO      = 2'd1;

    localparam logic [DUR_W-1:0]   BAR_MS      = 16'd60000;
    localparam logic [TEMPO_W-1:0] TEMPO_RESET = 8'd120;

    typedef struct packed {
        logic [TONE_W-1:0] divider;
        logic [TONE_W-1:0] prescaler;
        logic [DUR_W-1:0]  duration;
    } t_note;

    localparam int NOTE_W = $bits(t_note);

endpackage

@@ sv/tsp_ram.sv @@
// tsp_ram: generic single-write, single-read RAM with registered read data
// no dependencies

module tsp_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ sv/tsp_divider.sv @@
// tsp_divider: restoring divider, one quotient bit per cycle
// no dependencies; a zero divisor yields an all-ones quotient

module tsp_divider #(
    parameter int NUM_W = 16,
    parameter int DEN_W = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] r_rem;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_run;
    logic             r_done;

    logic [DEN_W:0]   w_shift;
    logic             w_fits;
    logic [DEN_W:0]   w_diff;

    assign w_shift = {r_rem, r_quo[NUM_W-1]};
    assign w_fits  = w_shift >= {1'b0, r_den};
    assign w_diff  = w_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CNT_W'(NUM_W);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_run) begin
            r_rem <= w_fits ? w_diff[DEN_W-1:0] : w_shift[DEN_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], w_fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

@@ sv/tone_sequence_player.sv @@
// tone_sequence_player: top level, command sequencer around the note RAM
// depends on tsp_pkg, tsp_ram, tsp_divider
//
//  channel | signals                                                | handshake
//  --------+--------------------------------------------------------+--------------------------
//  command | i_command, i_tone_divider .. i_length_count, i_rest    | i_start & !o_busy
//  result  | o_action, o_out_divider, o_out_prescaler, o_is_playing | o_valid, one cycle
//  config  | i_cfg_index, i_cfg_data                                | i_cfg_valid & o_cfg_ready
//
// start, stop, tick without a note fetch, an add_note that is not stored and unknown commands:
// result the cycle after the transfer, next command taken that same cycle.
// tick that plays a note: one note RAM read, then S_READ, then the result register.
// new_song and a stored add_note: 16 steps of the serial divider, then the result
// from S_PACE, or for add_note the product in S_UNIT and the RAM write in S_WRITE.
// synchronous reset clears control state and the entry valid bits; tempo reads 120.
// one result per command, and the receiver cannot stall it.

module tone_sequence_player
    import tsp_pkg::*;
#(
    parameter int MAX_NOTES = MAX_NOTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  logic [CMD_W-1:0]      i_command,
    input  logic [TONE_W-1:0]     i_tone_divider,
    input  logic [TONE_W-1:0]     i_prescaler_code,
    input  logic [LEN_W-1:0]      i_length_divisor,
    input  logic [LEN_W-1:0]      i_length_count,
    input  logic                  i_rest,
    output logic                  o_valid,
    output logic [ACT_W-1:0]      o_action,
    output logic [TONE_W-1:0]     o_out_divider,
    output logic [TONE_W-1:0]     o_out_prescaler,
    output logic                  o_is_playing,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW     = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
    localparam int PROD_W = LEN_W + DUR_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PACE,
        S_UNIT,
        S_WRITE,
        S_READ
    } t_state;

    t_state               r_state, n_state;
    logic [LEN_W-1:0]     r_note_count;
    logic [TEMPO_W-1:0]   r_tempo;
    logic [IDX_W-1:0]     r_song_len, n_song_len;
    logic [DUR_W-1:0]     r_pace, n_pace;
    logic [IDX_W-1:0]     r_index, n_index;
    logic [DUR_W-1:0]     r_countdown, n_countdown;
    logic                 r_active, n_active;
    logic                 r_table, n_table;
    logic [MAX_NOTES-1:0] r_valid, n_valid;
    logic [TONE_W-1:0]    r_note_div, n_note_div;
    logic [TONE_W-1:0]    r_note_pre, n_note_pre;
    logic [LEN_W-1:0]     r_lcnt, n_lcnt;
    logic [DUR_W-1:0]     r_dur, n_dur;

    logic                 r_o_valid, n_o_valid;
    logic [ACT_W-1:0]     r_o_action, n_o_action;
    logic [TONE_W-1:0]    r_o_div, n_o_div;
    logic [TONE_W-1:0]    r_o_pre, n_o_pre;
    logic                 r_o_play;

    logic                 w_accept;
    logic [DUR_W-1:0]     w_cd_dec;
    logic                 w_idx_lt;
    logic [AW-1:0]        w_addr;
    logic                 w_div_start;
    logic [DUR_W-1:0]     w_div_num;
    logic [TEMPO_W-1:0]   w_div_den;
    logic                 w_div_done;
    logic [DUR_W-1:0]     w_div_quot;
    logic [PROD_W-1:0]    w_prod;
    logic                 w_wr_en;
    t_note                w_wr_note;
    t_note                w_rd_note;
    t_note                w_fetched;

    assign w_accept = i_start && !o_busy;
    assign w_cd_dec = (r_countdown != '0) ? r_countdown - 1'b1 : '0;
    assign w_idx_lt = r_index < r_song_len;
    assign w_addr   = r_index[AW-1:0];
    assign w_prod   = PROD_W'(r_lcnt) * PROD_W'(w_div_quot);

    assign w_wr_note = '{divider: r_note_div, prescaler: r_note_pre, duration: r_dur};
    assign w_fetched = r_valid[w_addr] ? w_rd_note : '0;

    tsp_ram #(
        .WIDTH (NOTE_W),
        .DEPTH (MAX_NOTES)
    ) u_note_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_addr),
        .i_wr_data (w_wr_note),
        .i_rd_addr (w_addr),
        .o_rd_data (w_rd_note)
    );

    tsp_divider #(
        .NUM_W (DUR_W),
        .DEN_W (TEMPO_W)
    ) u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    always_comb begin
        n_state     = r_state;
        n_song_len  = r_song_len;
        n_pace      = r_pace;
        n_index     = r_index;
        n_countdown = r_countdown;
        n_active    = r_active;
        n_table     = r_table;
        n_valid     = r_valid;
        n_note_div  = r_note_div;
        n_note_pre  = r_note_pre;
        n_lcnt      = r_lcnt;
        n_dur       = r_dur;
        n_o_valid   = 1'b0;
        n_o_action  = ACT_NONE;
        n_o_div     = '0;
        n_o_pre     = '0;
        w_div_start = 1'b0;
        w_div_num   = r_pace;
        w_div_den   = TEMPO_W'({1'b0, r_lcnt});
        w_wr_en     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_note_div = i_rest ? '0 : i_tone_divider;
                    n_note_pre = i_prescaler_code;
                    n_lcnt     = i_length_count;
                    case (i_command)
                        CMD_NEW_SONG: begin
                            n_valid     = '0;
                            n_song_len  = (IDX_W'(r_note_count) < IDX_W'(MAX_NOTES)) ?
                                          IDX_W'(r_note_count) : IDX_W'(MAX_NOTES);
                            n_countdown = '0;
                            n_index     = '0;
                            n_active    = 1'b0;
                            n_table     = 1'b1;
                            w_div_start = 1'b1;
                            w_div_num   = BAR_MS;
                            w_div_den   = r_tempo;
                            n_state     = S_PACE;
                        end
                        CMD_ADD_NOTE: begin
                            if (r_table && w_idx_lt) begin
                                w_div_start = 1'b1;
                                w_div_num   = r_pace;
                                w_div_den   = TEMPO_W'({1'b0, i_length_divisor});
                                n_state     = S_UNIT;
                            end else begin
                                n_o_valid = 1'b1;
                            end
                        end
                        CMD_START: begin
                            if (r_table) begin
                                n_index     = '0;
                                n_active    = 1'b1;
                                n_countdown = '0;
                            end
                            n_o_valid = 1'b1;
                        end
                        CMD_STOP: begin
                            n_active   = 1'b0;
                            n_table    = 1'b0;
                            n_o_valid  = 1'b1;
                            n_o_action = ACT_SILENCE;
                        end
                        CMD_TICK: begin
                            n_o_valid = 1'b1;
                            if (r_active) begin
                                n_countdown = w_cd_dec;
                                if (!w_idx_lt && w_cd_dec == '0) begin
                                    n_active   = 1'b0;
                                    n_table    = 1'b0;
                                    n_o_action = ACT_SILENCE;
                                end else if (w_cd_dec == DUR_W'(1)) begin
                                    // buzzer goes quiet one tick ahead of the next note
                                    n_o_action = ACT_SILENCE;
                                end else if (w_cd_dec == '0) begin
                                    // note fetch: result waits for the RAM read
                                    n_o_valid = 1'b0;
                                    n_state   = S_READ;
                                end
                            end
                        end
                        default: begin
                            n_o_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_PACE: begin
                if (w_div_done) begin
                    n_pace    = w_div_quot;
                    n_o_valid = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_UNIT: begin
                if (w_div_done) begin
                    n_dur   = w_prod[DUR_W-1:0];
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                w_wr_en          = 1'b1;
                n_valid[w_addr]  = 1'b1;
                n_index          = r_index + 1'b1;
                n_o_valid        = 1'b1;
                n_state          = S_IDLE;
            end
            S_READ: begin
                if (w_fetched.divider != '0) begin
                    n_o_action = ACT_TONE;
                    n_o_div    = w_fetched.divider;
                    n_o_pre    = w_fetched.prescaler;
                end else begin
                    n_o_action = ACT_SILENCE;
                end
                n_countdown = w_fetched.duration;
                n_index     = r_index + 1'b1;
                n_o_valid   = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_note_count <= '0;
            r_tempo      <= TEMPO_RESET;
            r_song_len   <= '0;
            r_pace       <= '0;
            r_index      <= '0;
            r_countdown  <= '0;
            r_active     <= 1'b0;
            r_table      <= 1'b0;
            r_valid      <= '0;
            r_o_valid    <= 1'b0;
            r_o_action   <= ACT_NONE;
            r_o_div      <= '0;
            r_o_pre      <= '0;
            r_o_play     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_song_len  <= n_song_len;
            r_pace      <= n_pace;
            r_index     <= n_index;
            r_countdown <= n_countdown;
            r_active    <= n_active;
            r_table     <= n_table;
            r_valid     <= n_valid;
            r_o_valid   <= n_o_valid;
            r_o_action  <= n_o_action;
            r_o_div     <= n_o_div;
            r_o_pre     <= n_o_pre;
            r_o_play    <= n_active;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_NOTE_COUNT: r_note_count <= i_cfg_data[LEN_W-1:0];
                    CFG_TEMPO:      r_tempo      <= i_cfg_data[TEMPO_W-1:0];
                    default:        ;
                endcase
            end
        end
    end

    // operands of the current command, no reset
    always_ff @(posedge i_clk) begin
        r_note_div <= n_note_div;
        r_note_pre <= n_note_pre;
        r_lcnt     <= n_lcnt;
        r_dur      <= n_dur;
    end

    assign o_busy          = (r_state != S_IDLE) || !i_rst_n;
    assign o_cfg_ready     = i_rst_n;
    assign o_valid         = r_o_valid;
    assign o_action        = r_o_action;
    assign o_out_divider   = r_o_div;
    assign o_out_prescaler = r_o_pre;
    assign o_is_playing    = r_o_play;

    a_index_in_song: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_index <= r_song_len)
        else $error("note index ran past the song length");

    a_play_needs_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> r_table)
        else $error("playback active without a note table");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> (w_idx_lt && r_table))
        else $error("note RAM written outside the song");

    a_result_ends_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == S_IDLE))
        else $error("result shown while a command is still in progress");

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// tb: self-checking bench for tone_sequence_player, drives command and config
// transfers and checks every result against a local model of the player
// depends on tsp_pkg and the tone_sequence_player rtl

module tb;
    import tsp_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
    localparam int RANDOM_ITEMS  = 1700;
    localparam int DIRECTED_MAX  = 25;
    localparam int PHASE_ITEMS   = 150;
    localparam int SONG_TICK_CAP = 150;
    localparam int TAIL_CYCLES   = 24;
    localparam int SLOT_W        = $clog2(MAX_NOTES_DEF);

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [TONE_W-1:0] divider;
        logic [TONE_W-1:0] prescaler;
        logic [LEN_W-1:0]  ldiv;
        logic [LEN_W-1:0]  lcnt;
        logic              rest;
    } t_cmd_item;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [TONE_W-1:0] divider;
        logic [TONE_W-1:0] prescaler;
        logic              playing;
    } t_note_event;

    logic                  i_clk            = 1'b0;
    logic                  i_rst_n          = 1'b0;
    logic                  i_start          = 1'b0;
    logic                  o_busy;
    logic [CMD_W-1:0]      i_command        = '0;
    logic [TONE_W-1:0]     i_tone_divider   = '0;
    logic [TONE_W-1:0]     i_prescaler_code = '0;
    logic [LEN_W-1:0]      i_length_divisor = '0;
    logic [LEN_W-1:0]      i_length_count   = '0;
    logic                  i_rest           = 1'b0;
    logic                  o_valid;
    logic [ACT_W-1:0]      o_action;
    logic [TONE_W-1:0]     o_out_divider;
    logic [TONE_W-1:0]     o_out_prescaler;
    logic                  o_is_playing;
    logic                  i_cfg_valid      = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index      = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data       = '0;

    tone_sequence_player dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (i_start),
        .o_busy           (o_busy),
        .i_command        (i_command),
        .i_tone_divider   (i_tone_divider),
        .i_prescaler_code (i_prescaler_code),
        .i_length_divisor (i_length_divisor),
        .i_length_count   (i_length_count),
        .i_rest           (i_rest),
        .o_valid          (o_valid),
        .o_action         (o_action),
        .o_out_divider    (o_out_divider),
        .o_out_prescaler  (o_out_prescaler),
        .o_is_playing     (o_is_playing),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // player model state
    logic [TONE_W-1:0]        div_mem [MAX_NOTES_DEF];
    logic [TONE_W-1:0]        pre_mem [MAX_NOTES_DEF];
    logic [DUR_W-1:0]         dur_mem [MAX_NOTES_DEF];
    logic [MAX_NOTES_DEF-1:0] entry_ok;
    logic [IDX_W-1:0]         note_pos;
    logic [IDX_W-1:0]         song_len;
    logic [DUR_W-1:0]         countdown;
    logic [DUR_W-1:0]         bar_pace;
    logic                     playing;
    logic                     have_table;
    logic [LEN_W-1:0]         note_count_cfg;
    logic [TEMPO_W-1:0]       tempo_cfg;

    t_cmd_item   cmd_backlog[$];
    t_note_event expected_events[$];
    int unsigned n_queued   = 0;
    int unsigned n_taken    = 0;
    int unsigned errors     = 0;
    int unsigned gap_left   = 0;
    bit          gaps_on    = 1'b1;
    logic        cmd_xfer   = 1'b0;

    function automatic t_note_event advance_player(t_cmd_item c);
        t_note_event       ev;
        logic [DUR_W-1:0]  unit;
        logic [31:0]       span;
        logic [SLOT_W-1:0] slot;
        ev = '0;
        slot = note_pos[SLOT_W-1:0];
        case (c.command)
            CMD_NEW_SONG: begin
                entry_ok   = '0;
                song_len   = (note_count_cfg > MAX_NOTES_DEF) ? IDX_W'(MAX_NOTES_DEF)
                                                              : IDX_W'(note_count_cfg);
                bar_pace   = (tempo_cfg == 0) ? 16'hFFFF : BAR_MS / tempo_cfg;
                countdown  = '0;
                note_pos   = '0;
                playing    = 1'b0;
                have_table = 1'b1;
            end
            CMD_ADD_NOTE: begin
                if (have_table && note_pos < song_len) begin
                    unit = (c.ldiv == 0) ? 16'hFFFF : bar_pace / c.ldiv;
                    span = c.lcnt * unit;
                    div_mem[slot]  = c.rest ? '0 : c.divider;
                    pre_mem[slot]  = c.prescaler;
                    dur_mem[slot]  = span[DUR_W-1:0];
                    entry_ok[slot] = 1'b1;
                    note_pos++;
                end
            end
            CMD_START: begin
                if (have_table) begin
                    note_pos  = '0;
                    playing   = 1'b1;
                    countdown = '0;
                end
            end
            CMD_STOP: begin
                playing    = 1'b0;
                have_table = 1'b0;
                ev.action  = ACT_SILENCE;
            end
            CMD_TICK: begin
                if (playing) begin
                    if (countdown != 0)
                        countdown--;
                    if (note_pos >= song_len && countdown == 0) begin
                        playing    = 1'b0;
                        have_table = 1'b0;
                        ev.action  = ACT_SILENCE;
                    end else if (countdown == 1) begin
                        ev.action = ACT_SILENCE;
                    end else if (countdown == 0) begin
                        // entries not written since new_song play as silence of length zero
                        if (entry_ok[slot] && div_mem[slot] != 0) begin
                            ev.action    = ACT_TONE;
                            ev.divider   = div_mem[slot];
                            ev.prescaler = pre_mem[slot];
                        end else begin
                            ev.action = ACT_SILENCE;
                        end
                        countdown = entry_ok[slot] ? dur_mem[slot] : '0;
                        note_pos++;
                    end
                end
            end
            default: begin
            end
        endcase
        ev.playing = playing;
        return ev;
    endfunction

    task automatic compare_field(input string what, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            errors++;
        end
    endtask

    // monitor: result checks, config and command transfers into the model
    always @(posedge i_clk) begin : monitor
        t_note_event want;
        if (!i_rst_n) begin
            entry_ok       = '0;
            note_pos       = '0;
            song_len       = '0;
            countdown      = '0;
            bar_pace       = '0;
            playing        = 1'b0;
            have_table     = 1'b0;
            note_count_cfg = '0;
            tempo_cfg      = TEMPO_RESET;
            cmd_xfer      <= 1'b0;
        end else begin
            if (o_valid) begin
                if (expected_events.size() == 0) begin
                    $display("%0t: result with none expected, expected nothing, actual action %0d",
                             $time, o_action);
                    errors++;
                end else begin
                    want = expected_events.pop_front();
                    compare_field("action", 8'(want.action), 8'(o_action));
                    compare_field("divider", want.divider, o_out_divider);
                    compare_field("prescaler", want.prescaler, o_out_prescaler);
                    compare_field("is_playing", 8'(want.playing), 8'(o_is_playing));
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_NOTE_COUNT: note_count_cfg = i_cfg_data[LEN_W-1:0];
                    CFG_TEMPO:      tempo_cfg = i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_start && !o_busy) begin
                expected_events.push_back(advance_player(t_cmd_item'({i_command, i_tone_divider,
                    i_prescaler_code, i_length_divisor, i_length_count, i_rest})));
                n_taken++;
            end
            cmd_xfer <= i_start && !o_busy;
        end
    end

    // driver: one command held until its transfer, random gaps between commands
    always @(negedge i_clk) begin : driver
        t_cmd_item nxt;
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else if (i_start && !cmd_xfer) begin
            // still waiting for the transfer
        end else if (gap_left != 0) begin
            i_start  <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (cmd_backlog.size() != 0) begin
            nxt = cmd_backlog.pop_front();
            i_command        <= nxt.command;
            i_tone_divider   <= nxt.divider;
            i_prescaler_code <= nxt.prescaler;
            i_length_divisor <= nxt.ldiv;
            i_length_count   <= nxt.lcnt;
            i_rest           <= nxt.rest;
            i_start          <= 1'b1;
            if (gaps_on && $urandom_range(0, 4) == 0)
                gap_left <= $urandom_range(1, 4);
        end else begin
            i_start <= 1'b0;
        end
    end

    task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input logic [TONE_W-1:0] dv,
                             input logic [TONE_W-1:0] pr, input logic [LEN_W-1:0] ld,
                             input logic [LEN_W-1:0] lc, input logic rs);
        cmd_backlog.push_back('{cmd, dv, pr, ld, lc, rs});
        n_queued++;
    endtask

    task automatic queue_noise(input logic [CMD_W-1:0] cmd);
        queue_cmd(cmd, TONE_W'($urandom_range(0, 255)), TONE_W'($urandom_range(0, 255)),
                  LEN_W'($urandom_range(0, 127)), LEN_W'($urandom_range(0, 127)),
                  $urandom_range(0, 1) != 0);
    endtask

    // new_song, note writes, start, then ticks to roughly the end of the song; stray commands mixed in
    task automatic queue_song(input int unsigned len, input int unsigned pace);
        int unsigned n_add;
        int unsigned n_ticks;
        int unsigned unit;
        int unsigned ldiv;
        int unsigned lcnt;
        int unsigned play;
        play = 0;
        queue_noise(CMD_NEW_SONG);
        n_add = len;
        case ($urandom_range(0, 7))
            0: n_add = len + $urandom_range(1, 3);
            1: n_add = (len == 0) ? 0 : $urandom_range(0, len - 1);
            default: begin
            end
        endcase
        for (int i = 0; i < n_add; i++) begin
            ldiv = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 127) : $urandom_range(24, 127);
            lcnt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 4);
            if ($urandom_range(0, 11) == 0)
                queue_noise(($urandom_range(0, 1) != 0) ? CMD_TICK
                            : CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)));
            queue_cmd(CMD_ADD_NOTE, TONE_W'($urandom_range(0, 255)),
                      TONE_W'($urandom_range(0, 255)), LEN_W'(ldiv), LEN_W'(lcnt),
                      $urandom_range(0, 4) == 0);
            if (i < len) begin
                unit = (ldiv == 0) ? 65535 : pace / ldiv;
                play += ((lcnt * unit) & 16'hFFFF) + 1;
                if (play > SONG_TICK_CAP)
                    play = SONG_TICK_CAP;
            end
        end
        queue_noise(CMD_START);
        n_ticks = play + 2;
        if ($urandom_range(0, 3) == 0)
            n_ticks = $urandom_range(0, n_ticks);
        for (int i = 0; i < n_ticks; i++) begin
            if ($urandom_range(0, 59) == 0)
                queue_noise(CMD_START);
            else if ($urandom_range(0, 39) == 0)
                queue_noise(CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)));
            queue_noise(CMD_TICK);
        end
        if ($urandom_range(0, 1) != 0)
            queue_noise(CMD_STOP);
        if ($urandom_range(0, 3) == 0) begin
            queue_noise(CMD_ADD_NOTE);
            queue_noise(CMD_START);
            queue_noise(CMD_TICK);
        end
    endtask

    task automatic wait_idle();
        while (n_taken != n_queued || expected_events.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int unsigned notes;
        int unsigned tempo;
        int unsigned pace;
        int unsigned phase;
        int unsigned phase_base;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // no table yet: tick, add_note and start do nothing, spare codes are ignored
        queue_noise(CMD_TICK);
        queue_noise(CMD_ADD_NOTE);
        queue_noise(CMD_START);
        queue_noise(CMD_SPARE_LO);
        queue_noise(CMD_SPARE_HI);
        queue_noise(CMD_STOP);
        wait_idle();

        // zero tempo and zero divisor saturate, a long note wraps, the fourth write drops
        write_reg(CFG_NOTE_COUNT, 8'd3);
        write_reg(CFG_TEMPO, 8'd0);
        queue_noise(CMD_NEW_SONG);
        queue_cmd(CMD_ADD_NOTE, 8'hFF, 8'hFF, 7'd127, 7'd0, 1'b0);
        queue_cmd(CMD_ADD_NOTE, 8'hAA, 8'h55, 7'd1, 7'd0, 1'b1);
        queue_cmd(CMD_ADD_NOTE, 8'h01, 8'h00, 7'd0, 7'd127, 1'b0);
        queue_cmd(CMD_ADD_NOTE, 8'h80, 8'h80, 7'd64, 7'd1, 1'b0);
        queue_noise(CMD_START);
        repeat (4) queue_noise(CMD_TICK);
        queue_noise(CMD_STOP);
        // one stored note, the other entries read back cleared, then the song ends
        queue_noise(CMD_NEW_SONG);
        queue_cmd(CMD_ADD_NOTE, 8'h3C, 8'h07, 7'd5, 7'd0, 1'b0);
        queue_noise(CMD_START);
        repeat (4) queue_noise(CMD_TICK);
        wait_idle();

        phase = 0;
        while (n_queued < RANDOM_ITEMS + DIRECTED_MAX) begin
            case (phase)
                0: begin notes = 127; tempo = 255; end
                1: begin notes = 64;  tempo = 1;   end
                2: begin notes = 0;   tempo = 200; end
                3: begin notes = 65;  tempo = 240; end
                default: begin
                    notes = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 127)
                                                        : $urandom_range(1, 6);
                    tempo = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 255)
                                                        : $urandom_range(180, 255);
                end
            endcase
            if (n_queued > RANDOM_ITEMS * 7 / 8)
                gaps_on = 1'b0;
            write_reg(CFG_NOTE_COUNT, CFG_DATA_W'(notes));
            write_reg(CFG_TEMPO, CFG_DATA_W'(tempo));
            pace = (tempo == 0) ? 65535 : BAR_MS / tempo;
            phase_base = n_queued;
            while (n_queued - phase_base < PHASE_ITEMS &&
                   n_queued < RANDOM_ITEMS + DIRECTED_MAX)
                queue_song((notes > MAX_NOTES_DEF) ? MAX_NOTES_DEF : notes, pace);
            wait_idle();
            phase++;
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("tb: errors");
        $finish;
    end

endmodule
